/* rtl/pulse_presence_debounce_filter_top_macros.svh */
// assertion macros shared by the rtl files
`ifndef PULSE_PRESENCE_DEBOUNCE_FILTER_TOP_MACROS_SVH
`define PULSE_PRESENCE_DEBOUNCE_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PPDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppdf assertion failed");
`define PPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppdf assertion failed");
`else
`define PPDF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ppdf_pkg.sv */
// types and constants of the pulse presence debounce filter
package ppdf_pkg;

    localparam int TIME_W     = 32;
    localparam int DLY_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_OFF_DELAY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE  = 1'b1;

    typedef struct packed {
        logic [DLY_W-1:0] off_delay_ms;
        logic [DLY_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        logic              edge_seen;
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

    typedef struct packed {
        logic changed;
        logic presence;
    } t_res;

endpackage

/* rtl/ppdf_core.sv */
// presence state registers and the per-poll update logic
`include "pulse_presence_debounce_filter_top_macros.svh"

module ppdf_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  ppdf_pkg::t_cfg  i_cfg,
    input  ppdf_pkg::t_poll i_poll,
    output ppdf_pkg::t_res  o_res
);
    import ppdf_pkg::*;

    logic [TIME_W-1:0] r_last_active;
    logic              r_req_state;
    logic [TIME_W-1:0] r_req_time;
    logic              r_req_open;
    logic              r_applied;

    logic [TIME_W-1:0] n_last_active;
    logic              n_req_state;
    logic [TIME_W-1:0] n_req_time;
    logic              n_req_open;
    logic              n_applied;
    logic              n_changed;

    logic              active;
    logic [TIME_W-1:0] idle_time;
    logic [TIME_W-1:0] req_age;

    assign active    = i_poll.pin_level | i_poll.edge_seen;
    assign idle_time = i_poll.now_ms - r_last_active;

    always_comb begin
        n_last_active = r_last_active;
        n_req_state   = r_req_state;
        n_req_time    = r_req_time;
        n_req_open    = r_req_open;
        n_applied     = r_applied;
        n_changed     = 1'b0;

        // retrigger on activity, request off after the idle timeout
        if (active) begin
            n_last_active = i_poll.now_ms;
            if (!r_req_state) begin
                n_req_state = 1'b1;
                n_req_time  = i_poll.now_ms;
                n_req_open  = 1'b1;
            end
        end else if (idle_time > {{(TIME_W-DLY_W){1'b0}}, i_cfg.off_delay_ms}) begin
            if (r_req_state) begin
                n_req_state = 1'b0;
                n_req_time  = i_poll.now_ms;
                n_req_open  = 1'b1;
            end
        end

        req_age = i_poll.now_ms - n_req_time;

        // apply a request once it has stood for the debounce time
        if (n_req_open && (req_age >= {{(TIME_W-DLY_W){1'b0}}, i_cfg.debounce_ms})) begin
            if (r_applied != n_req_state) begin
                n_applied = n_req_state;
                n_changed = 1'b1;
            end
            n_req_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_active <= '0;
            r_req_state   <= 1'b0;
            r_req_time    <= '0;
            r_req_open    <= 1'b0;
            r_applied     <= 1'b0;
        end else if (i_step) begin
            r_last_active <= n_last_active;
            r_req_state   <= n_req_state;
            r_req_time    <= n_req_time;
            r_req_open    <= n_req_open;
            r_applied     <= n_applied;
        end
    end

    assign o_res.presence = n_applied;
    assign o_res.changed  = n_changed;

    `PPDF_ASSERT_NEXT(a_chg_flips, i_clk, i_rst_n, i_step && o_res.changed, r_applied != $past(r_applied))
    `PPDF_ASSERT_NEXT(a_chg_closes, i_clk, i_rst_n, i_step && o_res.changed, !r_req_open)
    `PPDF_ASSERT_NEXT(a_retrigger, i_clk, i_rst_n, i_step && active, r_last_active == $past(i_poll.now_ms) && r_req_state)
    `PPDF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !i_step, $stable(r_applied) && $stable(r_req_state) && $stable(r_req_open))
    `PPDF_ASSERT_SAME(a_open_req, i_clk, i_rst_n, r_req_open, r_req_state != r_applied || i_cfg.debounce_ms != '0 || !i_step || n_req_open == 1'b0)

endmodule

/* rtl/pulse_presence_debounce_filter_top.sv */
// top level: stream ports, config registers, input and result registers
// an accepted input beat goes to the input register, then its result to the result register
// throughput: one beat per cycle unless stalled; one update stage around the state registers
// a stalled result register holds a full input register, which then holds the input side
// reset: synchronous active low; clears both valid flags, config registers and state
`include "pulse_presence_debounce_filter_top_macros.svh"

module pulse_presence_debounce_filter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppdf_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ppdf_pkg::DLY_W-1:0]         i_cfg_wdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ppdf_pkg::IN_DATA_W-1:0]     i_s_tdata,  // now_ms, pin_level, edge_seen, zero pad
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ppdf_pkg::OUT_DATA_W-1:0]    o_m_tdata   // presence, changed, zero pad
);
    import ppdf_pkg::*;

    t_cfg  r_cfg;
    t_poll r_poll;
    logic  r_in_vld;
    t_res  r_res;
    logic  r_out_vld;

    t_res  step_res;
    logic  out_free;
    logic  step;

    assign out_free   = !r_out_vld || i_m_tready;
    assign step       = r_in_vld && out_free;
    assign o_s_tready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OFF_DELAY: r_cfg.off_delay_ms <= i_cfg_wdata;
                CFG_DEBOUNCE:  r_cfg.debounce_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_poll.now_ms    <= i_s_tdata[TIME_W-1:0];
            r_poll.pin_level <= i_s_tdata[TIME_W];
            r_poll.edge_seen <= i_s_tdata[TIME_W+1];
        end
    end

    ppdf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .i_poll  (r_poll),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_res.changed, r_res.presence};

    `PPDF_ASSERT_NEXT(a_step_fills, i_clk, i_rst_n, step, r_out_vld)
    `PPDF_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_vld && !i_m_tready, r_out_vld && $stable(r_res))
    `PPDF_ASSERT_SAME(a_no_step_when_full, i_clk, i_rst_n, r_out_vld && !i_m_tready, !step && (!r_in_vld || !o_s_tready))

endmodule
